/* rtl/core/nbcp_pkg.sv */
// shared types and constants for the naive bayes count and predict core
package nbcp_pkg;

    localparam int MAN_W     = 32;
    localparam int EXP_W     = 16;
    localparam int PROB_W    = 16;
    localparam int INT_STEPS = 17;
    localparam int FRAC_STEPS = 32;

    localparam logic [1:0] FUNC_ADD     = 2'd0;
    localparam logic [1:0] FUNC_REMOVE  = 2'd1;
    localparam logic [1:0] FUNC_PREDICT = 2'd2;

    localparam logic [1:0] CFG_ROOT = 2'd0;
    localparam logic [1:0] CFG_NCLS = 2'd1;
    localparam logic [1:0] CFG_ESS  = 2'd2;
    localparam logic [1:0] CFG_MASK = 2'd3;

    typedef struct packed {
        logic                    done;
        logic                    zero;
        logic [MAN_W-1:0]        quo;
        logic signed [EXP_W-1:0] expo;
    } t_div_res;

endpackage

/* rtl/core/nbcp_ram.sv */
// generic simple dual port ram with registered read
module nbcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/nbcp_div.sv */
// shared iterative divider: normalised ratio mantissa/exponent or plain integer quotient
module nbcp_div
    import nbcp_pkg::*;
#(
    parameter int DW = 51
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_int_mode,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output t_div_res      o_res
);

    localparam int SW = $clog2(DW + 1);
    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_NORM = 2'd1;
    localparam logic [1:0] D_DIV  = 2'd2;

    logic [1:0]              r_st;
    logic [DW:0]             r_n;
    logic [DW-1:0]           r_d;
    logic [SW-1:0]           r_sn;
    logic [SW-1:0]           r_sd;
    logic [5:0]              r_cnt;
    logic [MAN_W-1:0]        r_q;
    logic signed [EXP_W-1:0] r_exp;
    logic                    r_done;
    logic                    r_zero;

    logic        w_ge;
    logic [DW:0] w_diff;
    logic        w_lt;

    assign w_ge   = r_n >= {1'b0, r_d};
    assign w_diff = r_n - {1'b0, r_d};
    assign w_lt   = r_n[DW-1:0] < r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= D_IDLE;
            r_done <= 1'b0;
            r_zero <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                D_IDLE: begin
                    if (i_start) begin
                        r_q <= '0;
                        if (!i_int_mode && (i_num == '0 || i_den == '0)) begin
                            r_done <= 1'b1;
                            r_zero <= 1'b1;
                            r_exp  <= '0;
                        end else begin
                            r_zero <= 1'b0;
                            r_n    <= {1'b0, i_num};
                            r_d    <= i_den;
                            r_sn   <= '0;
                            r_sd   <= '0;
                            if (i_int_mode) begin
                                r_cnt <= 6'(INT_STEPS);
                                r_st  <= D_DIV;
                            end else begin
                                r_st <= D_NORM;
                            end
                        end
                    end
                end
                D_NORM: begin
                    // left-align both operands, a byte at a time where possible
                    if (!r_n[DW-1]) begin
                        if (r_n[DW-1 -: 8] == '0) begin
                            r_n  <= r_n << 8;
                            r_sn <= r_sn + SW'(8);
                        end else begin
                            r_n  <= r_n << 1;
                            r_sn <= r_sn + SW'(1);
                        end
                    end
                    if (!r_d[DW-1]) begin
                        if (r_d[DW-1 -: 8] == '0) begin
                            r_d  <= r_d << 8;
                            r_sd <= r_sd + SW'(8);
                        end else begin
                            r_d  <= r_d << 1;
                            r_sd <= r_sd + SW'(1);
                        end
                    end
                    if (r_n[DW-1] && r_d[DW-1]) begin
                        if (w_lt) begin
                            r_n <= r_n << 1;
                        end
                        r_exp <= EXP_W'($signed({1'b0, r_sd})) - EXP_W'($signed({1'b0, r_sn}))
                                 - (w_lt ? EXP_W'(32) : EXP_W'(31));
                        r_cnt <= 6'(FRAC_STEPS);
                        r_st  <= D_DIV;
                    end
                end
                D_DIV: begin
                    r_q   <= {r_q[MAN_W-2:0], w_ge};
                    r_n   <= (w_ge ? w_diff : r_n) << 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_done <= 1'b1;
                        r_st   <= D_IDLE;
                    end
                end
                default: begin
                    r_st <= D_IDLE;
                end
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.zero = r_zero;
    assign o_res.quo  = r_q;
    assign o_res.expo = r_exp;

endmodule

/* rtl/core/naive_bayes_count_predict_core.sv */
// naive bayes count tables and predictor with one shared iterative divider
// a row element without row end is buffered while the core stays idle; add/remove checks the
// class, updates its count and the counts of every present attribute; predict: per class one
// prior and one factor per used attribute, each a divider pass, then a summing pass over the
// classes and per class an integer division; one transaction at a time, busy meanwhile,
// no output stall; after reset a clear of all 4096 value count entries runs with busy high
module naive_bayes_count_predict_core
    import nbcp_pkg::*;
#(
    parameter int MAX_CLASSES = 8,
    parameter int MAX_ATTRS   = 32,
    parameter int MAX_VALUES  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_attr_index,
    input  logic [3:0]  i_attr_value,
    input  logic [4:0]  i_value_count,
    input  logic        i_is_missing,
    input  logic        i_row_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_class_index,
    output logic [15:0] o_class_probability,
    output logic        o_is_best,
    output logic        o_last_class
);

    localparam int KW       = $clog2(MAX_CLASSES);
    localparam int KCW      = $clog2(MAX_CLASSES + 1);
    localparam int AW       = $clog2(MAX_ATTRS);
    localparam int CA_DEPTH = MAX_CLASSES * MAX_ATTRS;
    localparam int VC_DEPTH = CA_DEPTH * MAX_VALUES;
    localparam int CAW      = $clog2(CA_DEPTH);
    localparam int VCW      = $clog2(VC_DEPTH);
    localparam int DW       = KW + 48;
    localparam int SUMW     = MAN_W + KW;
    localparam int PW       = KCW + 16;
    localparam int CW       = COUNT_WIDTH;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_UCHK   = 4'd2;
    localparam logic [3:0] S_UCC    = 4'd3;
    localparam logic [3:0] S_UATTR  = 4'd4;
    localparam logic [3:0] S_URMW   = 4'd5;
    localparam logic [3:0] S_PPRI   = 4'd6;
    localparam logic [3:0] S_PPRIW  = 4'd7;
    localparam logic [3:0] S_PATTR  = 4'd8;
    localparam logic [3:0] S_PRD    = 4'd9;
    localparam logic [3:0] S_PDIVW  = 4'd10;
    localparam logic [3:0] S_PMUL   = 4'd11;
    localparam logic [3:0] S_PSTORE = 4'd12;
    localparam logic [3:0] S_PSUM   = 4'd13;
    localparam logic [3:0] S_POUT   = 4'd14;
    localparam logic [3:0] S_POUTW  = 4'd15;

    // control
    logic [3:0]           r_state;
    logic [VCW-1:0]       r_clr;
    logic [AW-1:0]        r_i;
    logic [KW-1:0]        r_k;
    logic                 r_dir_add;
    logic [CW-1:0]        r_cc [MAX_CLASSES];
    logic [CW-1:0]        r_total;
    logic [MAX_ATTRS-1:0] r_row_miss;
    logic [4:0]           r_root;
    logic [3:0]           r_ncls;
    logic [15:0]          r_ess;
    logic [31:0]          r_mask;
    logic                 r_valid;
    logic [2:0]           r_out_idx;
    logic [15:0]          r_out_prob;
    logic                 r_out_best;
    logic                 r_out_last;

    // datapath
    logic [3:0]              r_row_val [MAX_ATTRS];
    logic [4:0]              r_row_vc  [MAX_ATTRS];
    logic                    r_cz;
    logic [MAN_W-1:0]        r_m;
    logic signed [EXP_W-1:0] r_e;
    logic [2*MAN_W-1:0]      r_prod;
    logic signed [EXP_W-1:0] r_fe;
    logic [MAN_W-1:0]        r_man [MAX_CLASSES];
    logic signed [EXP_W-1:0] r_ex  [MAX_CLASSES];
    logic                    r_zero [MAX_CLASSES];
    logic [KW-1:0]           r_best;
    logic [MAN_W-1:0]        r_bm;
    logic signed [EXP_W-1:0] r_bex;
    logic                    r_bz;
    logic [SUMW-1:0]         r_sum;

    logic            w_acc;
    logic            w_idx_ok;
    logic            w_val_ok;
    logic            w_func_ok;
    logic [AW-1:0]   w_widx;
    logic [KCW-1:0]  w_klim;
    logic            w_k_last;
    logic            w_i_last;
    logic [AW-1:0]   w_rb_addr;
    logic            w_present;
    logic [3:0]      w_rval;
    logic [4:0]      w_rvc;
    logic            w_root_ok;
    logic            w_sel;
    logic [CAW-1:0]  w_ca_addr;
    logic [VCW-1:0]  w_vc_addr;
    logic [CW-1:0]   w_ca_rd;
    logic [CW-1:0]   w_vc_rd;
    logic [CW-1:0]   w_ca_new;
    logic [CW-1:0]   w_vc_new;
    logic [CW-1:0]   w_cc_new;
    logic [CW-1:0]   w_tot_new;
    logic            w_ca_we;
    logic            w_vc_we;
    logic [CAW-1:0]  w_ca_waddr;
    logic [VCW-1:0]  w_vc_waddr;
    logic [CW-1:0]   w_ca_wdata;
    logic [CW-1:0]   w_vc_wdata;
    logic [PW-1:0]   w_kess;
    logic [20:0]     w_vess;
    logic            w_div_start;
    logic            w_div_int;
    logic [DW-1:0]   w_div_n;
    logic [DW-1:0]   w_div_d;
    t_div_res        w_div;
    logic signed [EXP_W-1:0] w_sh;
    logic [MAN_W-1:0] w_al;
    logic            w_gt;
    logic [15:0]     w_pr;

    assign busy      = (r_state != S_IDLE);
    assign w_acc     = start && !busy;
    assign w_idx_ok  = 32'(i_attr_index) < MAX_ATTRS;
    assign w_val_ok  = 32'(i_attr_value) < MAX_VALUES;
    assign w_func_ok = (i_func == FUNC_ADD) || (i_func == FUNC_REMOVE)
                       || (i_func == FUNC_PREDICT);
    assign w_widx    = AW'(i_attr_index);

    always_comb begin
        if (r_ncls < 4'd2) begin
            w_klim = KCW'(2);
        end else if (32'(r_ncls) > MAX_CLASSES) begin
            w_klim = KCW'(MAX_CLASSES);
        end else begin
            w_klim = KCW'(r_ncls);
        end
    end

    assign w_k_last = (KCW'(r_k) == w_klim - KCW'(1));
    assign w_i_last = (r_i == AW'(MAX_ATTRS - 1));

    // one read address for row presence and value: root during the class check, else the walk index
    assign w_rb_addr = (r_state == S_UCHK) ? AW'(r_root) : r_i;
    assign w_present = !r_row_miss[w_rb_addr];
    assign w_rval    = r_row_val[w_rb_addr];
    assign w_rvc     = r_row_vc[r_i];
    assign w_root_ok = 32'(r_root) < MAX_ATTRS;
    assign w_sel     = w_present && (32'(r_i) != 32'(r_root))
                       && ((32'(r_i) >= 32) || r_mask[5'(r_i)]);

    assign w_ca_addr = CAW'(32'(r_k) * MAX_ATTRS + 32'(r_i));
    assign w_vc_addr = VCW'((32'(r_k) * MAX_ATTRS + 32'(r_i)) * MAX_VALUES + 32'(w_rval));

    // saturating count updates
    assign w_ca_new  = r_dir_add ? ((&w_ca_rd) ? w_ca_rd : w_ca_rd + CW'(1))
                                 : ((|w_ca_rd) ? w_ca_rd - CW'(1) : '0);
    assign w_vc_new  = r_dir_add ? ((&w_vc_rd) ? w_vc_rd : w_vc_rd + CW'(1))
                                 : ((|w_vc_rd) ? w_vc_rd - CW'(1) : '0);
    assign w_cc_new  = r_dir_add ? ((&r_cc[r_k]) ? r_cc[r_k] : r_cc[r_k] + CW'(1))
                                 : ((|r_cc[r_k]) ? r_cc[r_k] - CW'(1) : '0);
    assign w_tot_new = r_dir_add ? ((&r_total) ? r_total : r_total + CW'(1))
                                 : ((|r_total) ? r_total - CW'(1) : '0);

    assign w_ca_we    = ((r_state == S_CLR) && (32'(r_clr) < CA_DEPTH)) || (r_state == S_URMW);
    assign w_vc_we    = (r_state == S_CLR) || (r_state == S_URMW);
    assign w_ca_waddr = (r_state == S_CLR) ? CAW'(r_clr) : w_ca_addr;
    assign w_vc_waddr = (r_state == S_CLR) ? r_clr : w_vc_addr;
    assign w_ca_wdata = (r_state == S_CLR) ? '0 : w_ca_new;
    assign w_vc_wdata = (r_state == S_CLR) ? '0 : w_vc_new;

    nbcp_ram #(
        .WIDTH (CW),
        .DEPTH (CA_DEPTH)
    ) u_ca_ram (
        .i_clk   (i_clk),
        .i_we    (w_ca_we),
        .i_waddr (w_ca_waddr),
        .i_wdata (w_ca_wdata),
        .i_raddr (w_ca_addr),
        .o_rdata (w_ca_rd)
    );

    nbcp_ram #(
        .WIDTH (CW),
        .DEPTH (VC_DEPTH)
    ) u_vc_ram (
        .i_clk   (i_clk),
        .i_we    (w_vc_we),
        .i_waddr (w_vc_waddr),
        .i_wdata (w_vc_wdata),
        .i_raddr (w_vc_addr),
        .o_rdata (w_vc_rd)
    );

    // divider operand selection
    assign w_kess = PW'(w_klim) * PW'(r_ess);
    assign w_vess = 21'(w_rvc) * 21'(r_ess);

    always_comb begin
        w_div_start = 1'b0;
        w_div_int   = 1'b0;
        w_div_n     = DW'({r_cc[r_k], 8'h00}) + DW'(r_ess);
        w_div_d     = DW'({r_total, 8'h00}) + DW'(w_kess);
        case (r_state)
            S_PPRI: begin
                w_div_start = 1'b1;
            end
            S_PRD: begin
                w_div_start = 1'b1;
                w_div_n     = DW'({w_vc_rd, 8'h00}) + DW'(r_ess);
                w_div_d     = DW'({w_ca_rd, 8'h00}) + DW'(w_vess);
            end
            S_POUT: begin
                w_div_start = (r_sum != '0);
                w_div_int   = 1'b1;
                w_div_n     = DW'({w_al, 16'h0000});
                w_div_d     = DW'({r_sum, 16'h0000});
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    nbcp_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_int_mode (w_div_int),
        .i_num      (w_div_n),
        .i_den      (w_div_d),
        .o_res      (w_div)
    );

    // class value aligned to the best exponent
    assign w_sh = r_bex - r_ex[r_k];
    assign w_al = (r_zero[r_k] || r_bz) ? '0
                : ((w_sh < 64) ? (r_man[r_k] >> w_sh[5:0]) : '0);

    assign w_gt = !r_cz && (r_bz || ((r_e != r_bex) ? (r_e > r_bex) : (r_m > r_bm)));
    assign w_pr = (w_div.quo[MAN_W-1:16] != '0) ? 16'hFFFF : w_div.quo[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_i        <= '0;
            r_k        <= '0;
            r_dir_add  <= 1'b0;
            r_cc       <= '{default: '0};
            r_total    <= '0;
            r_row_miss <= '1;
            r_root     <= 5'd0;
            r_ncls     <= 4'd2;
            r_ess      <= 16'd256;
            r_mask     <= '1;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROOT: r_root <= i_cfg_data[4:0];
                    CFG_NCLS: r_ncls <= i_cfg_data[3:0];
                    CFG_ESS:  r_ess  <= i_cfg_data[15:0];
                    CFG_MASK: r_mask <= i_cfg_data;
                    default:  r_mask <= r_mask;
                endcase
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + VCW'(1);
                    if (r_clr == VCW'(VC_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        // a row end with no action just drops the buffered row
                        if (i_row_end && !w_func_ok) begin
                            r_row_miss <= '1;
                        end else if (w_idx_ok) begin
                            r_row_miss[w_widx] <= i_is_missing || !w_val_ok;
                        end
                        if (i_row_end) begin
                            case (i_func)
                                FUNC_ADD: begin
                                    r_dir_add <= 1'b1;
                                    r_state   <= S_UCHK;
                                end
                                FUNC_REMOVE: begin
                                    r_dir_add <= 1'b0;
                                    r_state   <= S_UCHK;
                                end
                                FUNC_PREDICT: begin
                                    r_k     <= '0;
                                    r_state <= S_PPRI;
                                end
                                default: begin
                                    r_state <= S_IDLE;
                                end
                            endcase
                        end
                    end
                end
                S_UCHK: begin
                    if (w_root_ok && w_present && (32'(w_rval) < 32'(w_klim))) begin
                        r_k     <= KW'(w_rval);
                        r_state <= S_UCC;
                    end else begin
                        r_row_miss <= '1;
                        r_state    <= S_IDLE;
                    end
                end
                S_UCC: begin
                    r_cc[r_k] <= w_cc_new;
                    r_total   <= w_tot_new;
                    r_i       <= '0;
                    r_state   <= S_UATTR;
                end
                S_UATTR: begin
                    if (w_present) begin
                        r_state <= S_URMW;
                    end else if (w_i_last) begin
                        r_row_miss <= '1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_i <= r_i + AW'(1);
                    end
                end
                S_URMW: begin
                    if (w_i_last) begin
                        r_row_miss <= '1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_UATTR;
                    end
                end
                S_PPRI: begin
                    r_state <= S_PPRIW;
                end
                S_PPRIW: begin
                    if (w_div.done) begin
                        r_i     <= '0;
                        r_state <= w_div.zero ? S_PSTORE : S_PATTR;
                    end
                end
                S_PATTR: begin
                    if (w_sel) begin
                        r_state <= S_PRD;
                    end else if (w_i_last) begin
                        r_state <= S_PSTORE;
                    end else begin
                        r_i <= r_i + AW'(1);
                    end
                end
                S_PRD: begin
                    r_state <= S_PDIVW;
                end
                S_PDIVW: begin
                    if (w_div.done) begin
                        r_state <= w_div.zero ? S_PSTORE : S_PMUL;
                    end
                end
                S_PMUL: begin
                    if (w_i_last) begin
                        r_state <= S_PSTORE;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_PATTR;
                    end
                end
                S_PSTORE: begin
                    if (w_k_last) begin
                        r_k     <= '0;
                        r_state <= S_PSUM;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_state <= S_PPRI;
                    end
                end
                S_PSUM: begin
                    if (w_k_last) begin
                        r_k     <= '0;
                        r_state <= S_POUT;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_POUT, S_POUTW: begin
                    if ((r_state == S_POUT && r_sum == '0) ||
                        (r_state == S_POUTW && w_div.done)) begin
                        r_valid    <= 1'b1;
                        r_out_idx  <= 3'(r_k);
                        r_out_prob <= (r_state == S_POUT) ? 16'h0000 : w_pr;
                        r_out_best <= (r_k == r_best);
                        r_out_last <= w_k_last;
                        if (w_k_last) begin
                            r_row_miss <= '1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_POUT;
                        end
                    end else if (r_state == S_POUT) begin
                        r_state <= S_POUTW;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_idx_ok) begin
            r_row_vc[w_widx] <= i_value_count;
            if (!i_is_missing && w_val_ok) begin
                r_row_val[w_widx] <= i_attr_value;
            end
        end
        case (r_state)
            S_PPRIW: begin
                if (w_div.done) begin
                    r_cz <= w_div.zero;
                    r_m  <= w_div.quo;
                    r_e  <= w_div.expo;
                end
            end
            S_PDIVW: begin
                if (w_div.done) begin
                    r_cz   <= w_div.zero;
                    r_prod <= (2*MAN_W)'(r_m) * (2*MAN_W)'(w_div.quo);
                    r_fe   <= w_div.expo;
                end
            end
            S_PMUL: begin
                // keep the top 32 bits of the product, renormalised
                if (r_prod[2*MAN_W-1]) begin
                    r_m <= r_prod[2*MAN_W-1 -: MAN_W];
                    r_e <= r_e + r_fe + EXP_W'(32);
                end else begin
                    r_m <= r_prod[2*MAN_W-2 -: MAN_W];
                    r_e <= r_e + r_fe + EXP_W'(31);
                end
            end
            S_PSTORE: begin
                r_man[r_k]  <= r_cz ? '0 : r_m;
                r_ex[r_k]   <= r_cz ? '0 : r_e;
                r_zero[r_k] <= r_cz;
                if (r_k == '0 || w_gt) begin
                    r_best <= r_k;
                    r_bm   <= r_cz ? '0 : r_m;
                    r_bex  <= r_cz ? '0 : r_e;
                    r_bz   <= r_cz;
                end
                r_sum <= '0;
            end
            S_PSUM: begin
                r_sum <= r_sum + SUMW'(w_al);
            end
            default: begin
                r_sum <= r_sum;
            end
        endcase
    end

    assign o_valid             = r_valid;
    assign o_class_index       = r_out_idx;
    assign o_class_probability = r_out_prob;
    assign o_is_best           = r_out_best;
    assign o_last_class        = r_out_last;

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_PPRIW || r_state == S_PDIVW || r_state == S_POUTW))
        else $error("divider finished outside a wait state");

    a_last_ends_predict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_class) |-> (r_state == S_IDLE))
        else $error("final class result without return to idle");

    a_result_from_output_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_POUT || $past(r_state) == S_POUTW))
        else $error("result strobe outside the output phase");

endmodule

/* tb/nbcp_checker.sv */
// scoreboard for the naive bayes core: watches its ports, predicts class results, compares
`timescale 1ns / 1ps

module nbcp_checker
    import nbcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_attr_index,
    input  logic [3:0]  i_attr_value,
    input  logic [4:0]  i_value_count,
    input  logic        i_is_missing,
    input  logic        i_row_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  logic [2:0]  i_class_index,
    input  logic [15:0] i_class_probability,
    input  logic        i_is_best,
    input  logic        i_last_class,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int N_CLS  = 8;
    localparam int N_ATTR = 32;
    localparam int N_VAL  = 16;

    typedef struct {
        logic [2:0]  cls;
        logic [15:0] prob;
        logic        best;
        logic        last;
    } t_class_res;

    t_class_res  class_res_q[$];

    logic [4:0]  root_sel;
    logic [3:0]  ncls_reg;
    logic [15:0] ess_reg;
    logic [31:0] mask_reg;

    logic [31:0] cls_cnt [N_CLS];
    logic [31:0] cls_attr_cnt [N_CLS*N_ATTR];
    logic [31:0] val_cnt [N_CLS*N_ATTR*N_VAL];
    logic [31:0] rows_seen;
    logic [3:0]  row_val [N_ATTR];
    logic [4:0]  row_vcnt [N_ATTR];
    logic [31:0] row_absent;

    initial o_fail_count = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic logic [31:0] bump(input logic [31:0] c, input logic up);
        if (up) return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
        return (c == 32'd0) ? c : c - 32'd1;
    endfunction

    // n/d as q * 2^e with q normalised into [2^31, 2^32)
    function automatic logic to_mant(input logic [63:0] n_in, input logic [63:0] d_in,
                                     output logic [31:0] q, output int e);
        logic [63:0] n;
        logic [63:0] d;
        int ex;
        n = n_in;
        d = d_in;
        ex = 0;
        q = '0;
        e = 0;
        if (n == 0 || d == 0) return 1'b0;
        while (n < d) begin
            n = n << 1;
            ex--;
        end
        while (n >= (d << 1)) begin
            d = d << 1;
            ex++;
        end
        for (int b = 0; b < 32; b++) begin
            q = q << 1;
            if (n >= d) begin
                n = n - d;
                q[0] = 1'b1;
            end
            n = n << 1;
        end
        e = ex - 31;
        return 1'b1;
    endfunction

    function automatic logic gt(input int e1, input logic [31:0] m1, input logic z1,
                                input int e2, input logic [31:0] m2, input logic z2);
        if (z1) return 1'b0;
        if (z2) return 1'b1;
        if (e1 != e2) return e1 > e2;
        return m1 > m2;
    endfunction

    task automatic tally_row(input int k_n, input logic up);
        int k;
        int ci;
        int vi;
        if (row_absent[root_sel]) return;
        k = row_val[root_sel];
        if (k >= k_n) return;
        cls_cnt[k] = bump(cls_cnt[k], up);
        for (int i = 0; i < N_ATTR; i++) begin
            if (!row_absent[i]) begin
                ci = k * N_ATTR + i;
                vi = ci * N_VAL + row_val[i];
                cls_attr_cnt[ci] = bump(cls_attr_cnt[ci], up);
                val_cnt[vi] = bump(val_cnt[vi], up);
            end
        end
        rows_seen = bump(rows_seen, up);
    endtask

    task automatic predict_classes(input int k_n);
        logic [31:0] man [N_CLS];
        int          ex [N_CLS];
        logic        zr [N_CLS];
        logic [63:0] al [N_CLS];
        logic [63:0] ess;
        logic [63:0] sum;
        logic [63:0] p;
        logic [63:0] pr;
        logic [31:0] q;
        logic [31:0] m;
        int          e;
        int          ee;
        int          ci;
        int          d;
        int          best;
        logic        z;
        t_class_res  r;
        ess = {48'd0, ess_reg};
        sum = 0;
        best = 0;
        for (int k = 0; k < k_n; k++) begin
            z = !to_mant({32'd0, cls_cnt[k]} * 64'd256 + ess,
                         {32'd0, rows_seen} * 64'd256 + 64'(k_n) * ess, q, e);
            m = q;
            ee = e;
            for (int i = 0; i < N_ATTR && !z; i++) begin
                if (i == root_sel || row_absent[i] || !mask_reg[i]) continue;
                ci = k * N_ATTR + i;
                if (!to_mant({32'd0, val_cnt[ci*N_VAL + row_val[i]]} * 64'd256 + ess,
                             {32'd0, cls_attr_cnt[ci]} * 64'd256 + {59'd0, row_vcnt[i]} * ess,
                             q, e)) begin
                    z = 1'b1;
                    break;
                end
                p = {32'd0, m} * {32'd0, q};
                if (p[63]) begin
                    m = p[63:32];
                    ee += e + 32;
                end else begin
                    m = p[62:31];
                    ee += e + 31;
                end
            end
            man[k] = z ? 32'd0 : m;
            ex[k] = z ? 0 : ee;
            zr[k] = z;
        end
        for (int k = 1; k < k_n; k++)
            if (gt(ex[k], man[k], zr[k], ex[best], man[best], zr[best])) best = k;
        for (int k = 0; k < k_n; k++) begin
            al[k] = 0;
            if (!zr[k] && !zr[best]) begin
                d = ex[best] - ex[k];
                al[k] = (d < 64) ? ({32'd0, man[k]} >> d) : 64'd0;
            end
            sum += al[k];
        end
        for (int k = 0; k < k_n; k++) begin
            pr = 0;
            if (sum != 0) begin
                pr = (al[k] << 16) / sum;
                if (pr > 64'd65535) pr = 64'd65535;
            end
            r.cls = k[2:0];
            r.prob = pr[15:0];
            r.best = (k == best);
            r.last = (k == k_n - 1);
            class_res_q.push_back(r);
        end
    endtask

    task automatic take_element();
        int k_n;
        row_vcnt[i_attr_index] = i_value_count;
        if (i_is_missing) begin
            row_absent[i_attr_index] = 1'b1;
        end else begin
            row_absent[i_attr_index] = 1'b0;
            row_val[i_attr_index] = i_attr_value;
        end
        if (!i_row_end) return;
        k_n = ncls_reg;
        if (k_n < 2) k_n = 2;
        if (k_n > N_CLS) k_n = N_CLS;
        case (i_func)
            FUNC_ADD:     tally_row(k_n, 1'b1);
            FUNC_REMOVE:  tally_row(k_n, 1'b0);
            FUNC_PREDICT: predict_classes(k_n);
            default: ;
        endcase
        row_absent = '1;
    endtask

    always @(posedge i_clk) begin
        t_class_res r;
        if (!i_rst_n) begin
            root_sel = '0;
            ncls_reg = 4'd2;
            ess_reg = 16'd256;
            mask_reg = '1;
            rows_seen = '0;
            row_absent = '1;
            foreach (cls_cnt[k]) cls_cnt[k] = '0;
            foreach (cls_attr_cnt[k]) cls_attr_cnt[k] = '0;
            foreach (val_cnt[k]) val_cnt[k] = '0;
            class_res_q.delete();
        end else begin
            if (i_valid) begin
                if (class_res_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result class %0d", i_class_index));
                end else begin
                    r = class_res_q.pop_front();
                    if (i_class_index !== r.cls || i_class_probability !== r.prob ||
                        i_is_best !== r.best || i_last_class !== r.last)
                        report_mismatch($sformatf(
                            "class %0d prob %0d best %0b last %0b, want %0d %0d %0b %0b",
                            i_class_index, i_class_probability, i_is_best, i_last_class,
                            r.cls, r.prob, r.best, r.last));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROOT: root_sel = i_cfg_data[4:0];
                    CFG_NCLS: ncls_reg = i_cfg_data[3:0];
                    CFG_ESS:  ess_reg = i_cfg_data[15:0];
                    CFG_MASK: mask_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) take_element();
        end
        o_pending = class_res_q.size();
    end

endmodule

/* tb/tb_naive_bayes_count_predict_core.sv */
// stimulus and verdict for the naive bayes count and predict core
`timescale 1ns / 1ps

module tb_naive_bayes_count_predict_core;
    import nbcp_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic [4:0]  i_attr_index;
    logic [3:0]  i_attr_value;
    logic [4:0]  i_value_count;
    logic        i_is_missing;
    logic        i_row_end;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic [2:0]  o_class_index;
    logic [15:0] o_class_probability;
    logic        o_is_best;
    logic        o_last_class;

    int fail_count;
    int pending;
    int cycles;
    int elems_sent;
    logic no_idle;
    int n_cls;
    logic [4:0] root_cur;

    naive_bayes_count_predict_core u_top (.*);

    nbcp_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy),
        .i_func, .i_attr_index, .i_attr_value, .i_value_count, .i_is_missing, .i_row_end,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(o_valid), .i_class_index(o_class_index),
        .i_class_probability(o_class_probability), .i_is_best(o_is_best),
        .i_last_class(o_last_class),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_elem(input logic [1:0] func, input logic [4:0] idx,
                             input logic [3:0] val, input logic [4:0] vc,
                             input logic miss, input logic last);
        if (!no_idle && $urandom_range(0, 99) < 9) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= func;
        i_attr_index <= idx;
        i_attr_value <= val;
        i_value_count <= vc;
        i_is_missing <= miss;
        i_row_end <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        elems_sent++;
    endtask

    // drain all class results, then let a silent add or remove finish
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [4:0] root, input logic [3:0] ncls,
                            input logic [15:0] ess, input logic [31:0] mask);
        settle();
        write_reg(CFG_ROOT, {27'd0, root});
        write_reg(CFG_NCLS, {28'd0, ncls});
        write_reg(CFG_ESS, {16'd0, ess});
        write_reg(CFG_MASK, mask);
        root_cur = root;
        n_cls = (ncls < 2) ? 2 : (ncls > 8) ? 8 : ncls;
    endtask

    function automatic logic [4:0] rand_vcount();
        if ($urandom_range(0, 19) == 0) return 5'($urandom_range(0, 31));
        return 5'($urandom_range(1, 16));
    endfunction

    // one row: the class attribute first, then random attributes, or every index in order
    task automatic send_row(input int n, input logic [1:0] func, input logic [3:0] cls,
                            input logic cls_miss, input logic full);
        logic [4:0] idx;
        logic [3:0] val;
        logic miss;
        for (int j = 0; j < n; j++) begin
            idx = full ? 5'(j) : (j == 0) ? root_cur : 5'($urandom_range(0, 31));
            val = 4'($urandom_range(0, 15));
            miss = ($urandom_range(0, 9) == 0);
            if (idx == root_cur) begin
                val = cls;
                miss = cls_miss;
            end
            if ($urandom_range(0, 19) == 0) begin
                // noise element
                send_elem(2'($urandom), 5'($urandom), 4'($urandom), 5'($urandom),
                          1'($urandom), 1'b0);
            end
            send_elem(func, idx, val, rand_vcount(), miss, j == n - 1);
        end
    endtask

    task automatic random_phase(input int count);
        int target;
        int sel;
        logic [1:0] func;
        logic [3:0] cls;
        logic full;
        target = elems_sent + count;
        while (elems_sent < target) begin
            sel = $urandom_range(0, 99);
            func = (sel < 55) ? FUNC_ADD : (sel < 67) ? FUNC_REMOVE :
                   (sel < 95) ? FUNC_PREDICT : 2'd3;
            cls = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, n_cls - 1));
            full = ($urandom_range(0, 24) == 0);
            send_row(full ? 32 : $urandom_range(1, 6), func, cls,
                     $urandom_range(0, 19) == 0, full);
        end
    endtask

    initial begin
        cycles = 0;
        elems_sent = 0;
        no_idle = 1'b0;
        n_cls = 2;
        root_cur = '0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = FUNC_ADD;
        i_attr_index = '0;
        i_attr_value = '0;
        i_value_count = '0;
        i_is_missing = 1'b0;
        i_row_end = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ROOT;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on reset settings: empty tables, extremes, ignored rows
        settle();
        send_elem(FUNC_PREDICT, 5'd0, 4'd1, 5'd2, 1'b0, 1'b1);
        send_elem(FUNC_ADD, 5'd31, 4'd15, 5'd31, 1'b0, 1'b0);
        send_elem(FUNC_ADD, 5'd7, 4'd3, 5'd0, 1'b1, 1'b0);
        send_elem(FUNC_ADD, 5'd0, 4'd1, 5'd16, 1'b0, 1'b1);
        send_elem(FUNC_ADD, 5'd0, 4'd3, 5'd16, 1'b0, 1'b1);
        send_elem(FUNC_ADD, 5'd0, 4'd0, 5'd2, 1'b1, 1'b1);
        send_elem(FUNC_ADD, 5'd1, 4'd0, 5'd2, 1'b0, 1'b1);
        send_elem(FUNC_REMOVE, 5'd0, 4'd0, 5'd2, 1'b0, 1'b1);
        send_elem(FUNC_REMOVE, 5'd0, 4'd0, 5'd2, 1'b0, 1'b1);
        send_elem(2'd3, 5'd0, 4'd1, 5'd2, 1'b0, 1'b1);
        send_elem(FUNC_PREDICT, 5'd31, 4'd15, 5'd31, 1'b0, 1'b0);
        send_elem(FUNC_PREDICT, 5'd0, 4'd0, 5'd2, 1'b1, 1'b1);
        send_elem(FUNC_PREDICT, 5'd31, 4'd0, 5'd16, 1'b0, 1'b1);

        // zero smoothing while the row total is zero: every class value is zero
        set_regs(5'd31, 4'd0, 16'd0, 32'd0);
        send_elem(FUNC_PREDICT, 5'd2, 4'd5, 5'd6, 1'b0, 1'b1);
        send_row(4, FUNC_ADD, 4'd1, 1'b0, 1'b0);
        send_row(3, FUNC_PREDICT, 4'd0, 1'b0, 1'b0);
        random_phase(40);

        set_regs(5'd0, 4'd8, 16'hFFFF, 32'hFFFF_FFFF);
        send_row(32, FUNC_ADD, 4'd7, 1'b0, 1'b1);
        send_row(32, FUNC_PREDICT, 4'd7, 1'b0, 1'b1);
        random_phase(50);

        set_regs(5'd3, 4'd15, 16'd256, $urandom);
        no_idle = 1'b1;
        random_phase(50);
        no_idle = 1'b0;

        set_regs(5'($urandom_range(0, 31)), 4'($urandom_range(2, 8)), 16'($urandom), $urandom);
        random_phase(50);

        set_regs(5'd1, 4'd1, 16'd1, 32'hAAAA_5555);
        random_phase(30);

        settle();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
